[design/png_unf_pkg.sv]
// ----------------------------------------------------------------------------
// png_unf_pkg
// Shared types and codes for the PNG scanline unfilter block.
// ----------------------------------------------------------------------------
`default_nettype none

package png_unf_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_LENGTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_BYTES = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT   = 2'd2;

  typedef logic [2:0] filter_t;

  localparam filter_t FILTER_NONE  = 3'd0;
  localparam filter_t FILTER_SUB   = 3'd1;
  localparam filter_t FILTER_UP    = 3'd2;
  localparam filter_t FILTER_AVG   = 3'd3;
  localparam filter_t FILTER_PAETH = 3'd4;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] up;
    logic [7:0] upleft;
  } neighbours_t;

endpackage

`default_nettype wire

[design/png_unf_in_if.sv]
// ----------------------------------------------------------------------------
// png_unf_in_if
// Filtered byte stream channel: valid/ready with one byte and its markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface png_unf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       image_start;
  logic       last_in;

  modport source (output valid, raw_byte, image_start, last_in, input ready);
  modport sink   (input valid, raw_byte, image_start, last_in, output ready);
endinterface

`default_nettype wire

[design/png_unf_out_if.sv]
// ----------------------------------------------------------------------------
// png_unf_out_if
// Reconstructed pixel byte channel: valid/ready with byte and status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface png_unf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       row_end;
  logic       image_end;
  logic       error;

  modport source (output valid, pixel_byte, row_end, image_end, error, input ready);
  modport sink   (input valid, pixel_byte, row_end, image_end, error, output ready);
endinterface

`default_nettype wire

[design/png_unf_predict.sv]
// ----------------------------------------------------------------------------
// png_unf_predict
// Filter predictor: none, sub, up, average and paeth from the three neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module png_unf_predict
  import png_unf_pkg::*;
(
  input  filter_t     kind,
  input  neighbours_t nb,
  output logic [7:0]  pred
);

  logic [8:0] avg_sum;
  logic [7:0] dist_a;
  logic [7:0] dist_b;
  logic [9:0] sum_ab;
  logic [9:0] twice_c;
  logic [9:0] dist_c;
  logic [7:0] paeth;

  always_comb begin
    avg_sum = {1'b0, nb.left} + {1'b0, nb.up};
    // |p - a| = |b - c|, |p - b| = |a - c|, |p - c| = |a + b - 2c|
    dist_a  = (nb.up >= nb.upleft) ? nb.up - nb.upleft : nb.upleft - nb.up;
    dist_b  = (nb.left >= nb.upleft) ? nb.left - nb.upleft : nb.upleft - nb.left;
    sum_ab  = {2'b00, nb.left} + {2'b00, nb.up};
    twice_c = {1'b0, nb.upleft, 1'b0};
    dist_c  = (sum_ab >= twice_c) ? sum_ab - twice_c : twice_c - sum_ab;
    if (dist_a <= dist_b && {2'b00, dist_a} <= dist_c) begin
      paeth = nb.left;
    end else if ({2'b00, dist_b} <= dist_c) begin
      paeth = nb.up;
    end else begin
      paeth = nb.upleft;
    end
  end

  always_comb begin
    case (kind)
      FILTER_NONE:  pred = 8'd0;
      FILTER_SUB:   pred = nb.left;
      FILTER_UP:    pred = nb.up;
      FILTER_AVG:   pred = avg_sum[8:1];
      FILTER_PAETH: pred = paeth;
      default:      pred = 8'd0;
    endcase
  end

endmodule

`default_nettype wire

[design/png_scanline_unfilter_unit.sv]
// ----------------------------------------------------------------------------
// png_scanline_unfilter_unit
// Undoes PNG scanline filters on an inflated byte stream, one byte per beat.
// ----------------------------------------------------------------------------
// the input beat is held in the input stage and its result in the result reg
// throughput: 1 byte per cycle unless the output stalls; the line buffer read
//   is issued a beat ahead so its registered read data meets the byte in the
//   input stage
// reset (synchronous, rst high): registers back to 1, counters and neighbour
//   history cleared, stages empty; the line buffer is not cleared and holds
//   undefined bytes until a row writes them
`default_nettype none

module png_scanline_unfilter_unit
  import png_unf_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = 8192,
  parameter int MAX_PIXEL_BYTES = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  png_unf_in_if.sink             byte_stream,
  png_unf_out_if.source          pixel_stream
);

  localparam int CW = $clog2(MAX_ROW_BYTES);
  localparam int LW = CW + 1;
  localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int PW = $clog2(MAX_PIXEL_BYTES + 1);

  // configuration
  logic [13:0] row_length;
  logic [2:0]  pixel_bytes;
  logic [15:0] row_count;

  logic [LW-1:0] rl_eff;
  logic [PW-1:0] bpp_eff;
  logic [15:0]   rc_eff;

  // input stage
  logic       s1_valid;
  logic [7:0] s1_raw;
  logic       s1_start;
  logic       s1_last;

  // image state
  logic [CW-1:0] column_index;
  logic [15:0]   row_index;
  filter_t       filter_kind;
  logic          await_filter;
  logic          error_latched;
  logic [7:0]    left_history   [MAX_PIXEL_BYTES];
  logic [7:0]    upleft_history [MAX_PIXEL_BYTES];
  logic [SW-1:0] slot_count     [MAX_PIXEL_BYTES];

  // line buffer
  logic [7:0]    line_buf [MAX_ROW_BYTES];
  logic [7:0]    mem_q;
  logic [CW-1:0] raddr;

  // result register
  logic       out_valid;
  logic [7:0] out_pixel;
  logic       out_row_end;
  logic       out_image_end;
  logic       out_error;

  logic advance;
  logic s1_fire;

  // per-beat working values
  logic [CW-1:0] x;
  logic [15:0]   row_cur;
  filter_t       kind_cur;
  logic          await_cur;
  logic          err_cur;
  logic [SW-1:0] bidx;
  logic [SW-1:0] slot;
  logic          have_left;
  logic          have_up;
  neighbours_t   nb;
  logic [7:0]    pred;
  logic [7:0]    value;
  logic          row_end;
  logic          image_end;

  logic          res_valid;
  logic          res_error;
  logic [CW-1:0] column_next;
  logic [15:0]   row_next;
  filter_t       kind_next;
  logic          await_next;
  logic          err_next;
  logic          data_we;
  logic          clr_hist;
  logic          slot_adv;
  logic          slot_clr;

  assign advance           = !out_valid || pixel_stream.ready;
  assign s1_fire           = s1_valid && advance;
  assign byte_stream.ready = !s1_valid || advance;

  always_comb begin
    if (row_length == 14'd0) begin
      rl_eff = LW'(1);
    end else if (32'(row_length) > 32'(MAX_ROW_BYTES)) begin
      rl_eff = LW'(MAX_ROW_BYTES);
    end else begin
      rl_eff = LW'(row_length);
    end
    if (pixel_bytes == 3'd0) begin
      bpp_eff = PW'(1);
    end else if (32'(pixel_bytes) > 32'(MAX_PIXEL_BYTES)) begin
      bpp_eff = PW'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = PW'(pixel_bytes);
    end
    rc_eff = (row_count == 16'd0) ? 16'd1 : row_count;
  end

  always_comb begin
    // image start clears the state before the beat is taken
    x         = s1_start ? '0 : column_index;
    row_cur   = s1_start ? 16'd0 : row_index;
    kind_cur  = s1_start ? FILTER_NONE : filter_kind;
    await_cur = s1_start || await_filter;
    err_cur   = !s1_start && error_latched;
    bidx      = SW'(bpp_eff - 1'b1);
    slot      = s1_start ? '0 : slot_count[bidx];
    have_left = 32'(x) >= 32'(bpp_eff);
    have_up   = row_cur != 16'd0;

    nb.up     = have_up ? mem_q : 8'd0;
    nb.left   = have_left ? left_history[slot] : 8'd0;
    nb.upleft = (have_left && have_up) ? upleft_history[slot] : 8'd0;
  end

  png_unf_predict u_predict (
    .kind (kind_cur),
    .nb   (nb),
    .pred (pred)
  );

  always_comb begin
    value     = s1_raw + pred;
    row_end   = (LW'(x) + LW'(1)) >= rl_eff;
    image_end = row_end && ((17'(row_cur) + 17'd1) >= 17'(rc_eff));

    res_valid   = 1'b0;
    res_error   = 1'b0;
    column_next = x;
    row_next    = row_cur;
    kind_next   = kind_cur;
    await_next  = await_cur;
    err_next    = err_cur;
    data_we     = 1'b0;
    clr_hist    = s1_start;
    slot_adv    = 1'b0;
    slot_clr    = s1_start;

    if (err_cur) begin
      // dropping bytes until the next image start
    end else if (await_cur) begin
      if (s1_raw > 8'(FILTER_PAETH) || s1_last) begin
        res_valid = 1'b1;
        res_error = 1'b1;
        err_next  = 1'b1;
      end else begin
        kind_next  = s1_raw[2:0];
        await_next = 1'b0;
      end
    end else if (s1_last != image_end) begin
      res_valid = 1'b1;
      res_error = 1'b1;
      err_next  = 1'b1;
    end else begin
      res_valid = 1'b1;
      data_we   = 1'b1;
      if (image_end) begin
        column_next = '0;
        row_next    = 16'd0;
        kind_next   = FILTER_NONE;
        await_next  = 1'b1;
        clr_hist    = 1'b1;
        slot_clr    = 1'b1;
      end else if (row_end) begin
        column_next = '0;
        row_next    = row_cur + 16'd1;
        await_next  = 1'b1;
        slot_clr    = 1'b1;
      end else begin
        column_next = x + 1'b1;
        slot_adv    = 1'b1;
      end
    end
  end

  // next beat's column is read while this one retires
  assign raddr = s1_fire ? column_next : column_index;

  always_ff @(posedge clk) begin
    if (s1_fire && data_we) begin
      line_buf[x] <= value;
    end
    mem_q <= line_buf[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length  <= 14'd1;
      pixel_bytes <= 3'd1;
      row_count   <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_LENGTH:  row_length  <= cfg_data[13:0];
        CFG_PIXEL_BYTES: pixel_bytes <= cfg_data[2:0];
        CFG_ROW_COUNT:   row_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_stream.valid && byte_stream.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
    if (byte_stream.valid && byte_stream.ready) begin
      s1_raw   <= byte_stream.raw_byte;
      s1_start <= byte_stream.image_start;
      s1_last  <= byte_stream.last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index  <= '0;
      row_index     <= 16'd0;
      filter_kind   <= FILTER_NONE;
      await_filter  <= 1'b1;
      error_latched <= 1'b0;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_history[k]   <= 8'd0;
        upleft_history[k] <= 8'd0;
        slot_count[k]     <= '0;
      end
    end else if (s1_fire) begin
      column_index  <= column_next;
      row_index     <= row_next;
      filter_kind   <= kind_next;
      await_filter  <= await_next;
      error_latched <= err_next;
      if (clr_hist) begin
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          left_history[k]   <= 8'd0;
          upleft_history[k] <= 8'd0;
        end
      end else if (data_we) begin
        left_history[slot]   <= value;
        upleft_history[slot] <= nb.up;
      end
      // one column counter modulo each possible pixel size
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        if (slot_clr) begin
          slot_count[k] <= '0;
        end else if (slot_adv) begin
          slot_count[k] <= (slot_count[k] == SW'(k)) ? '0 : slot_count[k] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= res_valid;
    end else if (pixel_stream.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && res_valid) begin
      out_pixel     <= res_error ? 8'd0 : value;
      out_row_end   <= !res_error && row_end;
      out_image_end <= !res_error && image_end;
      out_error     <= res_error;
    end
  end

  assign pixel_stream.valid      = out_valid;
  assign pixel_stream.pixel_byte = out_pixel;
  assign pixel_stream.row_end    = out_row_end;
  assign pixel_stream.image_end  = out_image_end;
  assign pixel_stream.error      = out_error;

`ifndef SYNTH
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_pixel == 8'd0 && !out_row_end && !out_image_end)
    else $error("error beat carries pixel data or end flags");

  a_image_end_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_image_end |-> out_row_end)
    else $error("image end without row end");

  a_image_restart: assert property (@(posedge clk) disable iff (rst)
    s1_fire && res_valid && !res_error && image_end |=>
      column_index == '0 && row_index == 16'd0 && await_filter && !error_latched)
    else $error("counters not restarted after image end");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_raw) && $stable(column_index))
    else $error("input stage lost a beat while stalled");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PNG scanline unfilter unit. Feeds filtered
// scanline streams through the byte channel, reconstructs every byte with an
// in-bench copy of the unfilter arithmetic, and compares each pixel beat with
// the oldest prediction. Covers all five filters, bad filter bytes, stream
// length mismatches, register limits and randomly shaped images.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import png_unf_pkg::*;

  localparam int LINE_BYTES     = 8192;
  localparam int PIXEL_SPAN_MAX = 4;
  localparam int LINE_AW        = $clog2(LINE_BYTES);
  localparam int SLOT_W         = $clog2(PIXEL_SPAN_MAX);
  localparam int DRAIN_CYCLES   = 8;
  localparam int STALL_LIMIT    = 1000;
  localparam int RANDOM_BYTES   = 1780;

  // index with no register behind it
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       image_end;
    logic       err;
  } pixel_beat_t;

  typedef enum int {
    FAULT_NONE,
    FAULT_BAD_FILTER,
    FAULT_LAST_ON_FILTER,
    FAULT_LAST_FLIP,
    FAULT_RESTART,
    FAULT_NOISE
  } fault_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_ROW_LENGTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  png_unf_in_if  in_ch ();
  png_unf_out_if out_ch ();

  png_scanline_unfilter_unit #(
    .MAX_ROW_BYTES   (LINE_BYTES),
    .MAX_PIXEL_BYTES (PIXEL_SPAN_MAX)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_stream  (in_ch),
    .pixel_stream (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // unfilter predictor state
  // ---------------------------------------------------------------------------
  logic [13:0] row_length_q  = 14'd1;
  logic [2:0]  pixel_bytes_q = 3'd1;
  logic [15:0] row_count_q   = 16'd1;
  int unsigned eff_row_length = 1;
  int unsigned eff_pixel_bytes = 1;
  int unsigned eff_row_count = 1;

  logic [7:0]  line_mem [0:LINE_BYTES-1];
  logic [7:0]  left_hist [0:PIXEL_SPAN_MAX-1];
  logic [7:0]  upleft_hist [0:PIXEL_SPAN_MAX-1];
  int unsigned col_pos;
  int unsigned row_pos;
  filter_t     row_filter;
  bit          await_filter;
  bit          err_latched;

  pixel_beat_t expected_pixels [$];
  pixel_beat_t want;

  bit          src_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;
  int unsigned error_count = 0;
  int unsigned bytes_taken = 0;
  int unsigned beats_checked = 0;
  int unsigned images_sent = 0;
  int unsigned cfg_writes = 0;

  function automatic void clear_image_state();
    col_pos = 0;
    row_pos = 0;
    row_filter = FILTER_NONE;
    await_filter = 1'b1;
    err_latched = 1'b0;
    for (int i = 0; i < PIXEL_SPAN_MAX; i++) begin
      left_hist[SLOT_W'(i)] = 8'h00;
      upleft_hist[SLOT_W'(i)] = 8'h00;
    end
  endfunction

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int p, da, db, dc;
    p  = int'(a) + int'(b) - int'(c);
    da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    if (da <= db && da <= dc) return a;
    return (db <= dc) ? b : c;
  endfunction

  // returns 1 when the byte yields a pixel beat (or an error beat)
  function automatic bit unfilter_byte(input logic [7:0] raw, input logic st, input logic lst,
                                       output pixel_beat_t beat);
    int unsigned x, slot;
    logic [7:0]  left, up, upleft, pred, value;
    bit          last_col, last_row;
    beat = '0;
    if (st) clear_image_state();
    if (err_latched) return 1'b0;
    bytes_taken++;
    if (await_filter) begin
      if (raw > 8'(FILTER_PAETH) || lst) begin
        beat.err = 1'b1;
        err_latched = 1'b1;
        return 1'b1;
      end
      row_filter = filter_t'(raw[2:0]);
      await_filter = 1'b0;
      return 1'b0;
    end
    x = col_pos;
    slot = x % eff_pixel_bytes;
    up = (row_pos > 0 && x < LINE_BYTES) ? line_mem[LINE_AW'(x)] : 8'h00;
    left = (x >= eff_pixel_bytes) ? left_hist[SLOT_W'(slot)] : 8'h00;
    upleft = (x >= eff_pixel_bytes && row_pos > 0) ? upleft_hist[SLOT_W'(slot)] : 8'h00;
    case (row_filter)
      FILTER_SUB:   pred = left;
      FILTER_UP:    pred = up;
      FILTER_AVG:   pred = 8'((9'(left) + 9'(up)) >> 1);
      FILTER_PAETH: pred = paeth_pick(left, up, upleft);
      default:      pred = 8'h00;
    endcase
    value = raw + pred;
    last_col = (x + 1 >= eff_row_length);
    last_row = last_col && (row_pos + 1 >= eff_row_count);
    if (lst != last_row) begin
      beat.err = 1'b1;
      err_latched = 1'b1;
      return 1'b1;
    end
    left_hist[SLOT_W'(slot)] = value;
    upleft_hist[SLOT_W'(slot)] = up;
    if (x < LINE_BYTES) line_mem[LINE_AW'(x)] = value;
    beat.pixel = value;
    beat.row_end = last_col;
    beat.image_end = last_row;
    if (last_row) begin
      clear_image_state();
    end else if (last_col) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 32'hffff;
      await_filter = 1'b1;
    end else begin
      col_pos = x + 1;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
    case (idx)
      CFG_ROW_LENGTH:  row_length_q = data[13:0];
      CFG_PIXEL_BYTES: pixel_bytes_q = data[2:0];
      CFG_ROW_COUNT:   row_count_q = data[15:0];
      default: ;
    endcase
    eff_row_length = (row_length_q == 14'd0) ? 1 : 32'(row_length_q);
    if (eff_row_length > LINE_BYTES) eff_row_length = LINE_BYTES;
    eff_pixel_bytes = (pixel_bytes_q == 3'd0) ? 1 : 32'(pixel_bytes_q);
    if (eff_pixel_bytes > PIXEL_SPAN_MAX) eff_pixel_bytes = PIXEL_SPAN_MAX;
    eff_row_count = (row_count_q == 16'd0) ? 1 : 32'(row_count_q);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic st, input logic lst);
    int unsigned gap;
    pixel_beat_t beat;
    gap = src_gaps_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_byte <= b;
    in_ch.image_start <= st;
    in_ch.last_in <= lst;
    do @(posedge clk); while (!in_ch.ready);
    if (unfilter_byte(b, st, lst, beat)) expected_pixels = {expected_pixels, beat};
  endtask

  // filter bytes still in flight give no beat, so wait a little past the last one
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_image(input bit with_start, input fault_t fault);
    int unsigned rows, cols, bad_row, bad_col;
    int          bad_pos;
    logic [7:0]  b;
    bit          st, lst, hit;
    st = with_start;
    if (fault == FAULT_NOISE) begin
      repeat ($urandom_range(1, 8)) begin
        send_byte(8'($urandom), st, ($urandom_range(0, 3) == 0));
        st = ($urandom_range(0, 3) == 0);
      end
      return;
    end
    rows = eff_row_count;
    cols = eff_row_length;
    bad_row = $urandom_range(0, rows - 1);
    bad_col = $urandom_range(0, cols - 1);
    bad_pos = (fault == FAULT_LAST_FLIP || fault == FAULT_RESTART) ? int'(bad_col) : -1;
    images_sent++;
    for (int r = 0; r < int'(rows); r++) begin
      for (int c = -1; c < int'(cols); c++) begin
        hit = (fault != FAULT_NONE) && (r == int'(bad_row)) && (c == bad_pos);
        if (c < 0) begin
          b = 8'($urandom_range(int'(FILTER_NONE), int'(FILTER_PAETH)));
          lst = 1'b0;
        end else begin
          b = 8'($urandom);
          lst = (r == int'(rows) - 1) && (c == int'(cols) - 1);
        end
        if (hit) begin
          case (fault)
            FAULT_BAD_FILTER:     b = 8'($urandom_range(int'(FILTER_PAETH) + 1, 255));
            FAULT_LAST_ON_FILTER: lst = 1'b1;
            FAULT_LAST_FLIP:      lst = !lst;
            FAULT_RESTART:        st = 1'b1;
            default: ;
          endcase
        end
        send_byte(b, st, lst);
        st = 1'b0;
        if (hit && fault != FAULT_RESTART) begin
          // trailing bytes after an error should be swallowed
          send_byte(8'($urandom), 1'b0, 1'($urandom));
          send_byte(8'($urandom), 1'b0, 1'($urandom));
          return;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_each_filter();
    filter_t kinds [5];
    kinds = '{FILTER_NONE, FILTER_SUB, FILTER_UP, FILTER_AVG, FILTER_PAETH};
    wait_drained();
    cfg_write(CFG_ROW_LENGTH, 16'd3);
    cfg_write(CFG_PIXEL_BYTES, 16'd1);
    cfg_write(CFG_ROW_COUNT, 16'd5);
    for (int r = 0; r < 5; r++) begin
      send_byte(8'(kinds[3'(r)]), (r == 0), 1'b0);
      send_byte(8'hff, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'($urandom), 1'b0, (r == 4));
    end
    images_sent++;
  endtask

  task automatic test_stream_errors();
    wait_drained();
    cfg_write(CFG_ROW_LENGTH, 16'd2);
    cfg_write(CFG_PIXEL_BYTES, 16'd1);
    cfg_write(CFG_ROW_COUNT, 16'd2);
    // filter type out of range, then dropped bytes and a restart with a bad filter
    send_byte(8'h05, 1'b1, 1'b0);
    send_byte(8'h10, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hff, 1'b1, 1'b0);
    // end of stream flagged on a filter byte
    send_byte(8'(FILTER_NONE), 1'b1, 1'b1);
    // end of stream flagged too early
    send_byte(8'(FILTER_NONE), 1'b1, 1'b0);
    send_byte(8'h12, 1'b0, 1'b1);
    // end of stream missing on the last byte
    send_byte(8'(FILTER_SUB), 1'b1, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h81, 1'b0, 1'b0);
    send_byte(8'(FILTER_UP), 1'b0, 1'b0);
    send_byte(8'h33, 1'b0, 1'b0);
    send_byte(8'h44, 1'b0, 1'b0);
    // restart in mid-row, then a clean image
    send_byte(8'(FILTER_NONE), 1'b1, 1'b0);
    send_byte(8'haa, 1'b0, 1'b0);
    send_byte(8'(FILTER_AVG), 1'b1, 1'b0);
    send_byte(8'hfe, 1'b0, 1'b0);
    send_byte(8'hfd, 1'b0, 1'b0);
    send_byte(8'(FILTER_PAETH), 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h7f, 1'b0, 1'b1);
    // next image follows with no start marker
    send_byte(8'(FILTER_UP), 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'hc3, 1'b0, 1'b0);
    send_byte(8'(FILTER_SUB), 1'b0, 1'b0);
    send_byte(8'h0f, 1'b0, 1'b0);
    send_byte(8'hf0, 1'b0, 1'b1);
    images_sent += 2;
  endtask

  task automatic test_register_limits();
    wait_drained();
    // zero in every register acts as one
    cfg_write(CFG_ROW_LENGTH, 16'd0);
    cfg_write(CFG_PIXEL_BYTES, 16'd0);
    cfg_write(CFG_ROW_COUNT, 16'd0);
    send_image(1'b1, FAULT_NONE);
    wait_drained();
    cfg_write(CFG_SPARE, 16'ha5a5);
    send_image(1'b1, FAULT_NONE);
    // oversized rows and pixels clamp to the widest: a back-to-back partial row, left open
    wait_drained();
    cfg_write(CFG_ROW_LENGTH, 16'h3fff);
    cfg_write(CFG_PIXEL_BYTES, 16'hfffd);
    cfg_write(CFG_ROW_COUNT, 16'd2);
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    send_byte(8'(FILTER_PAETH), 1'b1, 1'b0);
    repeat (40) send_byte(8'($urandom), 1'b0, 1'b0);
    wait_drained();
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    cfg_write(CFG_ROW_LENGTH, 16'd16);
    cfg_write(CFG_PIXEL_BYTES, 16'd7);
    cfg_write(CFG_ROW_COUNT, 16'd3);
    send_image(1'b1, FAULT_NONE);
    // tallest image: a few rows only, left open
    wait_drained();
    cfg_write(CFG_ROW_LENGTH, 16'd1);
    cfg_write(CFG_PIXEL_BYTES, 16'd2);
    cfg_write(CFG_ROW_COUNT, 16'hffff);
    for (int r = 0; r < 6; r++) begin
      send_byte(8'($urandom_range(int'(FILTER_NONE), int'(FILTER_PAETH))), (r == 0), 1'b0);
      send_byte(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  task automatic test_midimage_registers();
    wait_drained();
    cfg_write(CFG_ROW_LENGTH, 16'd6);
    cfg_write(CFG_PIXEL_BYTES, 16'd1);
    cfg_write(CFG_ROW_COUNT, 16'd3);
    send_byte(8'(FILTER_SUB), 1'b1, 1'b0);
    repeat (3) send_byte(8'($urandom), 1'b0, 1'b0);
    // shorter rows and wider pixels from here on, stale history is used
    wait_drained();
    cfg_write(CFG_PIXEL_BYTES, 16'd3);
    cfg_write(CFG_ROW_LENGTH, 16'd4);
    send_byte(8'($urandom), 1'b0, 1'b0);
    send_byte(8'(FILTER_PAETH), 1'b0, 1'b0);
    repeat (4) send_byte(8'($urandom), 1'b0, 1'b0);
    send_byte(8'(FILTER_AVG), 1'b0, 1'b0);
    repeat (2) send_byte(8'($urandom), 1'b0, 1'b0);
    wait_drained();
    cfg_write(CFG_ROW_COUNT, 16'd2);
    send_byte(8'($urandom), 1'b0, 1'b0);
    send_byte(8'($urandom), 1'b0, 1'b1);
    images_sent++;
  endtask

  task automatic test_random_images();
    int unsigned stop_at, pick;
    bit          need_start;
    fault_t      fault;
    stop_at = bytes_taken + RANDOM_BYTES;
    while (bytes_taken < stop_at) begin
      wait_drained();
      pick = $urandom_range(0, 99);
      cfg_write(CFG_ROW_LENGTH, 16'((pick < 90) ? $urandom_range(1, 24) :
                                    (pick < 97) ? $urandom_range(25, 300) : 0));
      cfg_write(CFG_PIXEL_BYTES, 16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                                 : $urandom_range(1, 4)));
      pick = $urandom_range(0, 99);
      cfg_write(CFG_ROW_COUNT, 16'((pick < 85) ? $urandom_range(1, 6) :
                                   (pick < 92) ? 0 : $urandom_range(7, 12)));
      src_gaps_on = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      need_start = 1'b1;
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 99);
        fault = (pick < 72) ? FAULT_NONE :
                (pick < 78) ? FAULT_BAD_FILTER :
                (pick < 83) ? FAULT_LAST_ON_FILTER :
                (pick < 90) ? FAULT_LAST_FLIP :
                (pick < 95) ? FAULT_RESTART : FAULT_NOISE;
        send_image(need_start || ($urandom_range(0, 2) == 0), fault);
        need_start = (fault != FAULT_NONE);
      end
    end
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and checking
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = sink_stalls_on ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic void compare_field(input string name, input logic [7:0] exp_val,
                                        input logic [7:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, got_val);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      beats_checked++;
      if (expected_pixels.size() == 0) begin
        $error("pixel beat with nothing expected: pixel_byte %0h error %0b",
               out_ch.pixel_byte, out_ch.error);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        compare_field("pixel_byte", want.pixel, out_ch.pixel_byte);
        compare_field("row_end", 8'(want.row_end), 8'(out_ch.row_end));
        compare_field("image_end", 8'(want.image_end), 8'(out_ch.image_end));
        compare_field("error", 8'(want.err), 8'(out_ch.error));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid <= 1'b0;
    in_ch.raw_byte <= 8'h00;
    in_ch.image_start <= 1'b0;
    in_ch.last_in <= 1'b0;
    clear_image_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_each_filter();
    test_stream_errors();
    test_register_limits();
    test_midimage_registers();
    test_random_images();
    wait_drained();

    $display("covered %0d stream bytes over %0d images, %0d register writes",
             bytes_taken, images_sent, cfg_writes);
    $display("%0d pixel beats checked, %0d mismatches", beats_checked, error_count);
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
